[hdl/pki_pkg.sv]
// shared types, widths and helpers for the particle kinematics integrator
// no dependencies; imported by pki_step_unit and particle_kinematics_integrator
package pki_pkg;

	localparam int WORD_W        = 32;
	localparam int IDX_W         = 8;
	localparam int DELTA_W       = 20;
	localparam int FRAC_W        = 16;
	localparam int HALF_SH       = 17;
	localparam int HALF_W        = 2 * DELTA_W - HALF_SH;
	localparam int PRODV_W       = WORD_W + DELTA_W + 1;
	localparam int PRODA_W       = WORD_W + HALF_W + 1;
	localparam int SUM_W         = 43;
	localparam int PARTICLES_DEF = 64;

	typedef enum logic [2:0] {
		ACT_WR_POS = 3'd0,
		ACT_WR_VEL = 3'd1,
		ACT_WR_ACC = 3'd2,
		ACT_READ   = 3'd3,
		ACT_STEP   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MERGE,
		ST_REPLY,
		ST_STEP,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [2:0]               action;
		logic [IDX_W-1:0]         particle;
		logic signed [WORD_W-1:0] value_x;
		logic signed [WORD_W-1:0] value_y;
		logic [DELTA_W-1:0]       delta;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic signed [WORD_W-1:0] acc_x;
		logic signed [WORD_W-1:0] acc_y;
		logic                     status;
	} rsp_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] px;
		logic signed [WORD_W-1:0] py;
		logic signed [WORD_W-1:0] vx;
		logic signed [WORD_W-1:0] vy;
		logic signed [WORD_W-1:0] ax;
		logic signed [WORD_W-1:0] ay;
	} particle_t;

	localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[WORD_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[WORD_W-1:0];
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/pki_step_unit.sv]
// integration datapath for one particle: registered products, then sum and saturate
// depends on pki_pkg
module pki_step_unit import pki_pkg::*; #(
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DELTA_W-1:0] dt,
	input  logic [HALF_W-1:0]  half_dt2,
	input  logic               src_valid,
	input  logic [AW-1:0]      src_addr,
	input  particle_t          src_entry,
	output logic               dst_valid,
	output logic [AW-1:0]      dst_addr,
	output particle_t          dst_entry
);

	logic signed [PRODV_W-1:0] vdt_x, vdt_y, adt_x, adt_y;
	logic signed [PRODA_W-1:0] ah_x, ah_y;

	logic                               valid_s2;
	logic [AW-1:0]                      addr_s2;
	particle_t                          entry_s2;
	logic signed [PRODV_W-FRAC_W-1:0]   vdt_x_s2, vdt_y_s2, adt_x_s2, adt_y_s2;
	logic signed [PRODA_W-FRAC_W-1:0]   ah_x_s2, ah_y_s2;

	always_comb begin
		vdt_x = $signed(src_entry.vx) * $signed({1'b0, dt});
		vdt_y = $signed(src_entry.vy) * $signed({1'b0, dt});
		adt_x = $signed(src_entry.ax) * $signed({1'b0, dt});
		adt_y = $signed(src_entry.ay) * $signed({1'b0, dt});
		ah_x  = $signed(src_entry.ax) * $signed({1'b0, half_dt2});
		ah_y  = $signed(src_entry.ay) * $signed({1'b0, half_dt2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= src_valid;
		end
	end

	// dropping the low fraction bits of a signed product is a floor
	always_ff @(posedge clk) begin
		addr_s2  <= src_addr;
		entry_s2 <= src_entry;
		vdt_x_s2 <= vdt_x[PRODV_W-1:FRAC_W];
		vdt_y_s2 <= vdt_y[PRODV_W-1:FRAC_W];
		adt_x_s2 <= adt_x[PRODV_W-1:FRAC_W];
		adt_y_s2 <= adt_y[PRODV_W-1:FRAC_W];
		ah_x_s2  <= ah_x[PRODA_W-1:FRAC_W];
		ah_y_s2  <= ah_y[PRODA_W-1:FRAC_W];
	end

	always_comb begin
		dst_valid    = valid_s2;
		dst_addr     = addr_s2;
		dst_entry    = entry_s2;
		dst_entry.px = sat_word(SUM_W'(entry_s2.px) + SUM_W'(vdt_x_s2) + SUM_W'(ah_x_s2));
		dst_entry.py = sat_word(SUM_W'(entry_s2.py) + SUM_W'(vdt_y_s2) + SUM_W'(ah_y_s2));
		dst_entry.vx = sat_word(SUM_W'(entry_s2.vx) + SUM_W'(adt_x_s2));
		dst_entry.vy = sat_word(SUM_W'(entry_s2.vy) + SUM_W'(adt_y_s2));
	end

endmodule

[hdl/particle_kinematics_integrator.sv]
// top level: particle store, command sequencer and response register
// depends on pki_pkg and pki_step_unit
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+---------------------------------
//   cmd     | cmd_valid, cmd_ready     | in        | cmd_t: action, particle, value, delta
//   rsp     | rsp_valid, rsp_ready     | out       | rsp_t: pos, vel, acc, status
//
// write and read go through a store read, then a merge, before rsp valid is registered;
// a write out of range or a spare action code goes from idle straight to the reply state
// step issues one store read per cycle into a three stage update pipeline (read, multiply,
// sum and saturate with write back); the store port sets the rate
// reset clears one valid bit per entry; an entry not yet written reads as zero, no sweep
// a new command is taken once the previous response has left or leaves in that cycle
module particle_kinematics_integrator import pki_pkg::*; #(
	parameter int PARTICLES = PARTICLES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	particle_t mem [PARTICLES];
	logic [PARTICLES-1:0] vld_q;

	state_t  state_q, state_d;
	action_t op_q;
	logic [AW-1:0] addr_q, cnt_q, rd_addr, wr_addr;
	logic signed [WORD_W-1:0] val_x_q, val_y_q;
	logic [DELTA_W-1:0] dt_q;
	logic [HALF_W-1:0]  half_q;
	logic stat_q;

	logic      rd_vld_q;
	particle_t rd_q;
	particle_t entry_s1;
	logic      step_s1;
	logic [AW-1:0] addr_s1;

	logic      step_valid;
	logic [AW-1:0] step_addr;
	particle_t step_entry;

	logic      wr_en, issue, emit, cmd_fire, idx_ok;
	particle_t wr_data, merged;
	rsp_t      rsp_d, rsp_q;
	logic      rsp_valid_q;
	logic [IDX_W-1:0] idx_m1;
	logic [2*DELTA_W-1:0] dsq;

	assign cmd_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_ok = (cmd.particle != '0) && (cmd.particle <= IDX_W'(PARTICLES));
	assign idx_m1 = cmd.particle - IDX_W'(1);
	assign dsq    = cmd.delta * cmd.delta;

	assign entry_s1 = rd_vld_q ? rd_q : '0;

	always_comb begin
		merged = entry_s1;
		case (op_q)
			ACT_WR_POS: begin
				merged.px = val_x_q;
				merged.py = val_y_q;
			end
			ACT_WR_VEL: begin
				merged.vx = val_x_q;
				merged.vy = val_y_q;
			end
			ACT_WR_ACC: begin
				merged.ax = val_x_q;
				merged.ay = val_y_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		rsp_d   = '0;
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = merged;
		rd_addr = addr_q;
		issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					unique case (action_t'(cmd.action))
						ACT_WR_POS, ACT_WR_VEL, ACT_WR_ACC: begin
							state_d = idx_ok ? ST_READ : ST_REPLY;
						end
						ACT_READ: state_d = ST_READ;
						ACT_STEP: state_d = ST_STEP;
						default:  state_d = ST_REPLY;
					endcase
				end
			end
			ST_READ: state_d = ST_MERGE;
			ST_MERGE: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (op_q == ACT_READ) begin
					rsp_d.pos_x  = entry_s1.px;
					rsp_d.pos_y  = entry_s1.py;
					rsp_d.vel_x  = entry_s1.vx;
					rsp_d.vel_y  = entry_s1.vy;
					rsp_d.acc_x  = entry_s1.ax;
					rsp_d.acc_y  = entry_s1.ay;
					rsp_d.status = stat_q;
				end else begin
					wr_en = 1'b1;
				end
			end
			ST_REPLY: begin
				emit         = 1'b1;
				rsp_d.status = stat_q;
				state_d      = ST_IDLE;
			end
			ST_STEP: begin
				rd_addr = cnt_q;
				issue   = 1'b1;
				wr_en   = step_valid;
				wr_addr = step_addr;
				wr_data = step_entry;
				if (cnt_q == AW'(PARTICLES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				wr_en   = step_valid;
				wr_addr = step_addr;
				wr_data = step_entry;
				if (!step_s1 && !step_valid) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command fields, held for the whole operation
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q    <= action_t'(cmd.action);
			addr_q  <= idx_ok ? idx_m1[AW-1:0] : '0;
			val_x_q <= cmd.value_x;
			val_y_q <= cmd.value_y;
			dt_q    <= cmd.delta;
			half_q  <= dsq[2*DELTA_W-1:HALF_SH];
			stat_q  <= (cmd.action <= 3'(ACT_READ)) && !idx_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd_fire) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// particle store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q    <= mem[rd_addr];
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			step_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
			step_s1  <= issue;
		end
	end

	pki_step_unit #(
		.AW(AW)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.dt        (dt_q),
		.half_dt2  (half_q),
		.src_valid (step_s1),
		.src_addr  (addr_s1),
		.src_entry (entry_s1),
		.dst_valid (step_valid),
		.dst_addr  (step_addr),
		.dst_entry (step_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
